// File: rtl/core/psfp_pkg.sv
// Shared constants and types for the particle sensor frame parser.
// No dependencies.
package psfp_pkg;

  // Frame geometry
  localparam int FRAME_BYTES   = 32;
  localparam int MAX_WORDS     = 14;
  localparam int PAYLOAD_WORDS = ((FRAME_BYTES - 4) / 2) < MAX_WORDS ?
                                 ((FRAME_BYTES - 4) / 2) : MAX_WORDS;
  localparam int POS_W         = $clog2(FRAME_BYTES);
  localparam int IDX_W         = 4;
  localparam int WORD_W        = 16;

  // Start pair
  localparam logic [7:0] START_FIRST  = 8'h42;
  localparam logic [7:0] START_SECOND = 8'h4D;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_FIRST,
    ST_COLLECT,
    ST_READ,
    ST_LOAD
  } psfp_state_e;

endpackage

// File: rtl/core/particle_sensor_frame_parser.sv
// Particle sensor frame parser: start-pair hunt, checksum and word store.
// Depends on psfp_pkg.
//
// After the last frame byte a checksum error word is shown the next cycle; on a
// good frame each payload word goes through ST_READ (word store read port) and
// ST_LOAD (output register), and output stalls hold it in ST_LOAD.
// Throughput: one byte per cycle while parsing; no byte is taken while words
// are emitted or a result waits. Reset (async, active low) returns to hunting.
module particle_sensor_frame_parser
  import psfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  output logic                rx_stall_o,
  input  logic [7:0]          rx_byte_i,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output logic [IDX_W-1:0]    word_index_o,
  output logic [WORD_W-1:0]   word_value_o,
  output logic                status_o,
  output logic                last_o
);

  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_SUMEND = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_WRMAX  = POS_W'(FRAME_BYTES - 3);
  localparam logic [POS_W-1:0] POS_WR0    = POS_W'(3);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(PAYLOAD_WORDS - 1);
  localparam logic [WORD_W-1:0] SUM_START = WORD_W'(START_FIRST) + WORD_W'(START_SECOND);

  psfp_state_e           state_q, state_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [WORD_W-1:0]     sum_q, sum_d;
  logic [7:0]            pend_q, pend_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;

  logic                  res_valid_q, res_valid_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  logic [WORD_W-1:0]     res_word_q, res_word_d;
  logic                  res_status_q, res_status_d;
  logic                  res_last_q, res_last_d;

  // Word store
  logic [WORD_W-1:0]     mem_q [MAX_WORDS];
  logic [WORD_W-1:0]     rdata_q;
  logic                  rd_en;
  logic                  wr_en;
  logic [POS_W-1:0]      wr_k;
  logic [WORD_W-1:0]     wr_word;

  logic                  rx_take;
  logic                  slot_free;

  assign rx_stall_o = res_valid_q ||
                      !(state_q == ST_HUNT || state_q == ST_FIRST || state_q == ST_COLLECT);
  assign rx_take    = rx_valid_i && !rx_stall_o;
  assign slot_free  = !res_valid_q || !res_stall_i;

  // Payload word address for the current byte position
  assign wr_k    = (pos_q - POS_WR0) >> 1;
  assign wr_word = {pend_q, rx_byte_i};

  // Next state, parse and emit sequencing
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    sum_d        = sum_q;
    pend_d       = pend_q;
    rd_idx_d     = rd_idx_q;
    res_valid_d  = res_valid_q && res_stall_i;
    res_idx_d    = res_idx_q;
    res_word_d   = res_word_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    unique case (state_q)
      ST_HUNT, ST_FIRST: begin
        if (rx_take) begin
          if (state_q == ST_FIRST && rx_byte_i == START_SECOND) begin
            state_d = ST_COLLECT;
            pos_d   = POS_W'(2);
            sum_d   = SUM_START;
            pend_d  = rx_byte_i;
          end else if (rx_byte_i == START_FIRST) begin
            state_d = ST_FIRST;
            pos_d   = POS_W'(1);
          end else begin
            state_d = ST_HUNT;
            pos_d   = '0;
            sum_d   = '0;
          end
        end
      end
      ST_COLLECT: begin
        if (rx_take) begin
          if (pos_q >= POS_LAST) begin
            // frame complete: check sum against trailing big-endian checksum
            pos_d = '0;
            sum_d = '0;
            if (wr_word != sum_q) begin
              state_d      = ST_HUNT;
              res_valid_d  = 1'b1;
              res_idx_d    = '0;
              res_word_d   = '0;
              res_status_d = STATUS_ERR;
              res_last_d   = 1'b1;
            end else begin
              state_d  = ST_READ;
              rd_idx_d = '0;
            end
          end else begin
            if (pos_q < POS_SUMEND) begin
              sum_d = sum_q + WORD_W'(rx_byte_i);
            end
            wr_en  = pos_q[0] && pos_q >= POS_WR0 && pos_q <= POS_WRMAX &&
                     int'(wr_k) < MAX_WORDS;
            pend_d = rx_byte_i;
            pos_d  = pos_q + POS_W'(1);
          end
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          res_valid_d  = 1'b1;
          res_idx_d    = rd_idx_q;
          res_word_d   = rdata_q;
          res_status_d = STATUS_OK;
          res_last_d   = (rd_idx_q == IDX_LAST);
          if (rd_idx_q == IDX_LAST) begin
            state_d = ST_HUNT;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
            state_d  = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      pos_q       <= '0;
      sum_q       <= '0;
      pend_q      <= '0;
      rd_idx_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      pend_q      <= pend_d;
      rd_idx_q    <= rd_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    res_idx_q    <= res_idx_d;
    res_word_q   <= res_word_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  // Word store: write while parsing, registered read while emitting
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[IDX_W'(wr_k)] <= wr_word;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  assign res_valid_o  = res_valid_q;
  assign word_index_o = res_idx_q;
  assign word_value_o = res_word_q;
  assign status_o     = res_status_q;
  assign last_o       = res_last_q;

  // Checks
  a_no_rx_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_take |-> !(state_q == ST_READ || state_q == ST_LOAD))
    else $error("byte taken while emitting words");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o == STATUS_ERR) |-> (last_o && word_index_o == '0 &&
                                                word_value_o == '0))
    else $error("checksum error result malformed");

  a_ok_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o == STATUS_OK) |-> (word_index_o <= IDX_LAST &&
                                               last_o == (word_index_o == IDX_LAST)))
    else $error("payload word index out of range");

  a_back_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_stall_i && last_o) |-> (state_q == ST_HUNT && pos_q == '0))
    else $error("parser not hunting after frame end");

endmodule

// File: bench/particle_sensor_frame_parser_checker.sv
`timescale 1ns / 100ps
// Checker for the particle sensor frame parser: watches both channels, tracks
// the start-pair hunt and frame sum, and compares every result word in order.
// Depends on psfp_pkg.
module particle_sensor_frame_parser_checker
  import psfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  input  logic              rx_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              res_valid_o,
  input  logic              res_stall_i,
  input  logic [IDX_W-1:0]  word_index_o,
  input  logic [WORD_W-1:0] word_value_o,
  input  logic              status_o,
  input  logic              last_o,
  output int                fail_count_o,
  output int                pending_words_o
);

  typedef enum logic [1:0] {
    SYNC_HUNT,
    SYNC_GOT_FIRST,
    SYNC_COLLECT
  } sync_phase_e;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] value;
    logic              status;
    logic              last;
  } frame_word_t;

  // Parser shadow state
  sync_phase_e       phase;
  int                byte_pos;
  logic [15:0]       run_sum;
  logic [7:0]        prev_byte;
  logic [WORD_W-1:0] stored_words [MAX_WORDS];

  frame_word_t expected_words [$];
  frame_word_t got_word;
  frame_word_t exp_word;
  int          fail_count;

  task automatic restart_hunt();
    phase    = SYNC_HUNT;
    byte_pos = 0;
    run_sum  = '0;
  endtask

  // Advance the shadow parser by one accepted byte; queue any words it releases
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [15:0] check;
    int          k;
    if (phase == SYNC_COLLECT) begin
      if (byte_pos + 1 >= FRAME_BYTES) begin
        // final byte closes the frame: checksum is the last two bytes
        check = {prev_byte, b};
        if (check != run_sum) begin
          expected_words.push_back(frame_word_t'{'0, '0, STATUS_ERR, 1'b1});
        end else begin
          for (int n = 0; n < PAYLOAD_WORDS; n++) begin
            expected_words.push_back(frame_word_t'{IDX_W'(n), stored_words[n], STATUS_OK,
                                                   n == PAYLOAD_WORDS - 1});
          end
        end
        restart_hunt();
      end else begin
        if (byte_pos + 2 < FRAME_BYTES) run_sum = run_sum + 16'(b);
        // odd positions complete a big-endian payload word
        if ((byte_pos % 2 == 1) && byte_pos >= 3 && byte_pos + 3 <= FRAME_BYTES) begin
          k = (byte_pos - 3) / 2;
          if (k < MAX_WORDS) stored_words[k] = {prev_byte, b};
        end
        prev_byte = b;
        byte_pos++;
      end
    end else begin
      // a broken start pair re-examines the same byte
      if (phase == SYNC_GOT_FIRST && b == START_SECOND) begin
        phase     = SYNC_COLLECT;
        byte_pos  = 2;
        run_sum   = 16'(START_FIRST) + 16'(START_SECOND);
        prev_byte = b;
      end else if (b == START_FIRST) begin
        phase    = SYNC_GOT_FIRST;
        byte_pos = 1;
      end else begin
        restart_hunt();
      end
    end
  endtask

  // Compare on result handshake, then predict on byte handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_hunt();
      prev_byte = '0;
      foreach (stored_words[i]) stored_words[i] = '0;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (res_valid_o && !res_stall_i) begin
        got_word = frame_word_t'{word_index_o, word_value_o, status_o, last_o};
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word idx=%0d value=%h status=%0d last=%0d",
                   $time, got_word.idx, got_word.value, got_word.status, got_word.last);
        end else begin
          exp_word = expected_words.pop_front();
          if (got_word !== exp_word) begin
            fail_count++;
            $display("%0t: word mismatch expected idx=%0d value=%h status=%0d last=%0d",
                     $time, exp_word.idx, exp_word.value, exp_word.status, exp_word.last);
            $display("%0t:                  actual idx=%0d value=%h status=%0d last=%0d",
                     $time, got_word.idx, got_word.value, got_word.status, got_word.last);
          end
        end
      end
      if (rx_valid_i && !rx_stall_o) parse_rx_byte(rx_byte_i);
    end
    fail_count_o    <= fail_count;
    pending_words_o <= expected_words.size();
  end

endmodule

// File: bench/particle_sensor_frame_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top for the particle sensor frame parser: byte stimulus, random
// stalls and the verdict. Depends on psfp_pkg, the frame parser and its checker.
module particle_sensor_frame_parser_tb;
  import psfp_pkg::*;

  // Total bytes to send; the last random pick may add up to one more frame
  localparam int BYTE_BUDGET = 300;

  // Fill patterns for generated frames
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_ZEROS  = 2;
  localparam int FILL_START  = 3;

  logic              clk_i;
  logic              rst_ni;
  logic              rx_valid_i;
  logic              rx_stall_o;
  logic [7:0]        rx_byte_i;
  logic              res_valid_o;
  logic              res_stall_i;
  logic [IDX_W-1:0]  word_index_o;
  logic [WORD_W-1:0] word_value_o;
  logic              status_o;
  logic              last_o;

  int fail_count;
  int pending_words;
  int bytes_sent;
  bit idle_on;

  particle_sensor_frame_parser u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_stall_o   (rx_stall_o),
    .rx_byte_i    (rx_byte_i),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  particle_sensor_frame_parser_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_o      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .res_valid_o     (res_valid_o),
    .res_stall_i     (res_stall_i),
    .word_index_o    (word_index_o),
    .word_value_o    (word_value_o),
    .status_o        (status_o),
    .last_o          (last_o),
    .fail_count_o    (fail_count),
    .pending_words_o (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result-side back-pressure
  initial begin
    res_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      res_stall_i <= idle_on && ($urandom_range(99) < 29);
    end
  end

  // Biased byte: start codes and extremes show up often
  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(9))
      0:       return START_FIRST;
      1:       return START_SECOND;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Present one byte; valid is only touched once per falling edge
  task automatic send_rx_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (idle_on && ($urandom_range(99) < 29)) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (rx_stall_o);
    bytes_sent++;
  endtask

  // Hold off the sender until every predicted word has come out
  task automatic hold_until_drained();
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
  endtask

  // Full frame with header, payload pattern and good or corrupted checksum
  task automatic send_frame(input bit good_sum, input int fill);
    logic [7:0]  frame [FRAME_BYTES];
    logic [15:0] sum;
    frame[0] = START_FIRST;
    frame[1] = START_SECOND;
    for (int i = 2; i < FRAME_BYTES - 2; i++) begin
      case (fill)
        FILL_ONES:  frame[i] = 8'hFF;
        FILL_ZEROS: frame[i] = 8'h00;
        FILL_START: frame[i] = (i % 2 == 0) ? START_FIRST : START_SECOND;
        default:    frame[i] = pick_data_byte();
      endcase
    end
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 2; i++) sum = sum + 16'(frame[i]);
    if (!good_sum) sum = sum ^ 16'($urandom_range(1, 65535));
    frame[FRAME_BYTES-2] = sum[15:8];
    frame[FRAME_BYTES-1] = sum[7:0];
    for (int i = 0; i < FRAME_BYTES; i++) send_rx_byte(frame[i]);
  endtask

  // Stimulus
  initial begin
    int pick;
    int burst;
    rst_ni     = 1'b0;
    rx_valid_i = 1'b0;
    rx_byte_i  = '0;
    idle_on    = 1'b1;
    bytes_sent = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: noise, broken start pairs, extremes, bad checksum
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_rx_byte(START_SECOND);
    send_rx_byte(START_FIRST);
    send_rx_byte(8'h00);
    send_rx_byte(START_FIRST);
    send_frame(1'b1, FILL_ONES);
    send_frame(1'b0, FILL_ZEROS);
    hold_until_drained();
    send_frame(1'b1, FILL_START);
    send_frame(1'b1, FILL_ZEROS);
    hold_until_drained();

    // Random: mostly well-formed frames, some noise and broken starts
    while (bytes_sent < BYTE_BUDGET) begin
      idle_on = !(bytes_sent >= 150 && bytes_sent < 250);
      pick = $urandom_range(99);
      if (pick < 72) begin
        send_frame($urandom_range(99) < 80, FILL_RANDOM);
      end else if (pick < 86) begin
        burst = $urandom_range(1, 6);
        repeat (burst) send_rx_byte(pick_data_byte());
      end else begin
        send_rx_byte(START_FIRST);
        send_rx_byte(pick_data_byte() == START_SECOND ? START_FIRST : pick_data_byte());
      end
      if ($urandom_range(9) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
